// ===== hdl/mpaq_pkg.sv =====
// mpaq_pkg: shared types and codes for the media presence arm qualifier
// event kinds, input and result words, config and state structs
// no dependencies
package mpaq_pkg;

  localparam int unsigned CntW  = 8;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    KIND_OBSERVE    = 3'd0,
    KIND_OBS_FAILED = 3'd1,
    KIND_FAILURE    = 3'd2,
    KIND_RETRY      = 3'd3,
    KIND_BLOCK      = 3'd4,
    KIND_EJECT      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    REG_STABLE_TARGET = 2'd0,
    REG_REARM_TARGET  = 2'd1,
    REG_RETRY_LIMIT   = 2'd2
  } reg_idx_e;

  localparam logic [CntW-1:0] StableTargetRst = 8'd3;
  localparam logic [CntW-1:0] RearmTargetRst  = 8'd3;
  localparam logic [CntW-1:0] RetryLimitRst   = 8'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic       drive_seen;
    logic       media_known;
    logic       media_loaded;
    logic       failure_transient;
    logic       tray_ejected;
  } in_word_t;

  typedef struct packed {
    logic start_attempt;
    logic armed;
    logic pending_failure;
  } out_word_t;

  typedef struct packed {
    logic [CntW-1:0] stable_target;
    logic [CntW-1:0] rearm_target;
    logic [CntW-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] stable_count;
    logic [CntW-1:0] rearm_count;
    logic [CntW-1:0] transient_count;
    logic            attempt_allowed;
    logic            command_needed;
  } qual_state_t;

endpackage

// ===== hdl/mpaq_cfg.sv =====
// mpaq_cfg: apb-style register file for the three qualifier targets
// depends on mpaq_pkg
module mpaq_cfg import mpaq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_STABLE_TARGET: cfg_d.stable_target = pwdata[CntW-1:0];
        REG_REARM_TARGET:  cfg_d.rearm_target  = pwdata[CntW-1:0];
        REG_RETRY_LIMIT:   cfg_d.retry_limit   = pwdata[CntW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_target <= StableTargetRst;
      cfg_q.rearm_target  <= RearmTargetRst;
      cfg_q.retry_limit   <= RetryLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STABLE_TARGET: prdata = {{(DataW-CntW){1'b0}}, cfg_q.stable_target};
      REG_REARM_TARGET:  prdata = {{(DataW-CntW){1'b0}}, cfg_q.rearm_target};
      REG_RETRY_LIMIT:   prdata = {{(DataW-CntW){1'b0}}, cfg_q.retry_limit};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/mpaq_core.sv =====
// mpaq_core: qualifier state registers and the per-word update logic
// depends on mpaq_pkg
module mpaq_core import mpaq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t res_o
);

  qual_state_t st_q, st_d;
  logic            absent;
  logic            start;
  logic [CntW-1:0] rearm_inc;
  logic [CntW-1:0] stable_inc;

  assign absent = ~word_i.drive_seen | (word_i.media_known & ~word_i.media_loaded);

  // saturating increments
  assign rearm_inc  = (st_q.rearm_count < cfg_i.rearm_target) ?
                      st_q.rearm_count + 8'd1 : st_q.rearm_count;
  assign stable_inc = (st_q.stable_count < cfg_i.stable_target) ?
                      st_q.stable_count + 8'd1 : st_q.stable_count;

  always_comb begin
    st_d  = st_q;
    start = 1'b0;
    case (word_i.kind)
      KIND_OBSERVE: begin
        if (absent) begin
          st_d.stable_count = '0;
          st_d.rearm_count  = rearm_inc;
          if (rearm_inc >= cfg_i.rearm_target) begin
            st_d.transient_count = '0;
            st_d.attempt_allowed = 1'b1;
            st_d.command_needed  = 1'b0;
          end
        end else begin
          st_d.rearm_count  = '0;
          st_d.stable_count = stable_inc;
          if (st_q.attempt_allowed && (stable_inc >= cfg_i.stable_target)) begin
            start                = 1'b1;
            st_d.attempt_allowed = 1'b0;
          end
        end
      end
      KIND_OBS_FAILED: begin
        st_d.stable_count = '0;
      end
      KIND_FAILURE: begin
        st_d.stable_count = '0;
        st_d.rearm_count  = '0;
        if (word_i.failure_transient && (st_q.transient_count < cfg_i.retry_limit)) begin
          st_d.transient_count = st_q.transient_count + 8'd1;
          st_d.attempt_allowed = 1'b1;
          st_d.command_needed  = 1'b0;
        end else begin
          st_d.attempt_allowed = 1'b0;
          st_d.command_needed  = 1'b1;
        end
      end
      KIND_RETRY: begin
        st_d.stable_count    = cfg_i.stable_target;
        st_d.rearm_count     = '0;
        st_d.transient_count = '0;
        st_d.attempt_allowed = 1'b1;
        st_d.command_needed  = 1'b0;
      end
      KIND_BLOCK: begin
        st_d = '0;
      end
      KIND_EJECT: begin
        st_d = '0;
        st_d.attempt_allowed = word_i.tray_ejected;
      end
      default: st_d = st_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q                 <= '0;
      st_q.attempt_allowed <= 1'b1;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign res_o.start_attempt   = start;
  assign res_o.armed           = st_d.attempt_allowed;
  assign res_o.pending_failure = st_d.command_needed | (st_d.transient_count != '0);

endmodule

// ===== hdl/media_presence_arm_qualifier_top.sv =====
// media_presence_arm_qualifier_top: input register, qualifier core, result register
// depends on mpaq_pkg, mpaq_cfg, mpaq_core
//
// usage
// - input channel: in_valid_i / in_stall_o carry one event word (in_data_i)
// - output channel: out_valid_o / out_stall_i carry one result word per event
// - a word moves at a rising edge with valid high and stall low
// - config: apb-style port, stable_target at 0x0, rearm_target at 0x4,
//   retry_limit at 0x8; write only while no event is in flight
// - the event word moves through the input register and then the result
//   register; a stalled result holds it in the input register
// - throughput: one event per cycle while the receiver does not stall, set by the
//   combinational state update between the input register and the result register
// - the result register frees itself in the cycle it is taken, so a new
//   event is accepted while a finished result waits
// - when the receiver stalls, the result holds; one more event waits in the
//   input register, and then in_stall_o rises
// - reset clears both valid flags, arms the block, zeroes all counters and
//   loads each target register with 3
module media_presence_arm_qualifier_top import mpaq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t      cfg;
  in_word_t  s1_word_q;
  logic      s1_valid_q, s1_valid_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;
  out_word_t res;
  logic      advance;
  logic      in_take;

  mpaq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the state updates exactly when an event leaves the input register
  mpaq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .word_i (s1_word_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // event moves on when the result register is empty or being drained
  assign advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_word_q <= in_data_i;
    end
    if (advance) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

`ifndef SYNTHESIS
  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a start pulse always disarms
  a_start_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.start_attempt) |-> !out_data_o.armed)
    else $error("start pulse with block still armed");

  // a new result comes only from an event held in the input register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(s1_valid_q))
    else $error("result without a source event");
`endif

endmodule

// ===== tb/sv/media_presence_arm_qualifier_top_tb.sv =====
// media_presence_arm_qualifier_top_tb: self-checking bench for the media presence arm qualifier
// predicts every result word from its own copy of the counters, flags and targets
// depends on mpaq_pkg and media_presence_arm_qualifier_top
module media_presence_arm_qualifier_top_tb;
  import mpaq_pkg::*;

  // event kinds the block ignores
  localparam logic [2:0] KindSpare0 = 3'd6;
  localparam logic [2:0] KindSpare1 = 3'd7;
  // register slot past the last target, writes there must be ignored
  localparam logic [1:0] RegUnused  = 2'd3;
  localparam int unsigned MaxWait   = 12;
  localparam int unsigned SettleCyc = 4;

  typedef enum int unsigned {IDLE_NONE, IDLE_UNIFORM, IDLE_RARE} idle_style_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_word_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_data_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  media_presence_arm_qualifier_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // qualifier prediction: targets as last written, counters and flags as the
  // block should hold them after every accepted event word
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] stable_goal = StableTargetRst;
  logic [CntW-1:0] rearm_goal  = RearmTargetRst;
  logic [CntW-1:0] retry_cap   = RetryLimitRst;

  logic [CntW-1:0] stable_cnt    = '0;
  logic [CntW-1:0] rearm_cnt     = '0;
  logic [CntW-1:0] transient_cnt = '0;
  logic            attempt_ok    = 1'b1;
  logic            cmd_needed    = 1'b0;

  in_word_t    pending_events[$];
  out_word_t   expected_results[$];
  idle_style_e idle_style = IDLE_UNIFORM;
  int unsigned fail_cnt = 0;

  // applies one event to the predicted state and returns the result word it causes
  function automatic out_word_t qualify_event(in_word_t w);
    out_word_t r;
    logic      absent;
    r = '0;
    case (w.kind)
      KIND_OBSERVE: begin
        // unknown media status counts as present as long as the drive is seen
        absent = !w.drive_seen || (w.media_known && !w.media_loaded);
        if (absent) begin
          stable_cnt = '0;
          if (rearm_cnt < rearm_goal) rearm_cnt++;
          if (rearm_cnt >= rearm_goal) begin
            transient_cnt = '0;
            attempt_ok    = 1'b1;
            cmd_needed    = 1'b0;
          end
        end else begin
          rearm_cnt = '0;
          if (stable_cnt < stable_goal) stable_cnt++;
          // one-shot start: fires once, then waits for a rearm
          if (attempt_ok && stable_cnt >= stable_goal) begin
            r.start_attempt = 1'b1;
            attempt_ok      = 1'b0;
          end
        end
      end
      KIND_OBS_FAILED: begin
        stable_cnt = '0;
      end
      KIND_FAILURE: begin
        stable_cnt = '0;
        rearm_cnt  = '0;
        if (w.failure_transient && transient_cnt < retry_cap) begin
          transient_cnt++;
          attempt_ok = 1'b1;
          cmd_needed = 1'b0;
        end else begin
          // hard failure or retries used up: a command must come first
          attempt_ok = 1'b0;
          cmd_needed = 1'b1;
        end
      end
      KIND_RETRY: begin
        stable_cnt    = stable_goal;
        rearm_cnt     = '0;
        transient_cnt = '0;
        attempt_ok    = 1'b1;
        cmd_needed    = 1'b0;
      end
      KIND_BLOCK, KIND_EJECT: begin
        stable_cnt    = '0;
        rearm_cnt     = '0;
        transient_cnt = '0;
        attempt_ok    = (w.kind == KIND_EJECT) && w.tray_ejected;
        cmd_needed    = 1'b0;
      end
      default: begin
        // spare kinds leave the state alone
      end
    endcase
    r.armed           = attempt_ok;
    r.pending_failure = cmd_needed || (transient_cnt != '0);
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    case (idle_style)
      IDLE_NONE:    return 0;
      IDLE_UNIFORM: return $urandom_range(0, MaxWait);
      default:      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MaxWait) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled at the rising edge
  // ---------------------------------------------------------------------------
  logic      in_taken  = 1'b0;
  logic      out_taken = 1'b0;
  out_word_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result word %b arrived with nothing expected", out_data_o);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.start_attempt !== want.start_attempt) begin
            $error("start_attempt: expected %0b, got %0b",
                   want.start_attempt, out_data_o.start_attempt);
            fail_cnt++;
          end
          if (out_data_o.armed !== want.armed) begin
            $error("armed: expected %0b, got %0b", want.armed, out_data_o.armed);
            fail_cnt++;
          end
          if (out_data_o.pending_failure !== want.pending_failure) begin
            $error("pending_failure: expected %0b, got %0b",
                   want.pending_failure, out_data_o.pending_failure);
            fail_cnt++;
          end
        end
      end
      // the word taken now passes the input and result registers first, so it can never match this edge
      if (in_valid_i && !in_stall_o) expected_results.push_back(qualify_event(in_data_i));
    end
  end

  // ---------------------------------------------------------------------------
  // event driver: a word holds while stalled, then a random gap follows it
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (pending_events.size() != 0) begin
          in_data_i  <= pending_events.pop_front();
          in_valid_i <= 1'b1;
          gap_left = draw_wait();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: after each taken word, stall the next one a random while
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) stall_left = draw_wait();
      if (stall_left != 0 && out_valid_o) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // config writes: setup then access cycle, upper data bits are junk that the
  // block must drop
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [CntW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_STABLE_TARGET: stable_goal = val;
      REG_REARM_TARGET:  rearm_goal  = val;
      REG_RETRY_LIMIT:   retry_cap   = val;
      default: begin
      end
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_targets(logic [CntW-1:0] s, logic [CntW-1:0] r, logic [CntW-1:0] l);
    write_reg(REG_STABLE_TARGET, s);
    write_reg(REG_REARM_TARGET, r);
    write_reg(REG_RETRY_LIMIT, l);
  endtask

  // waits until every queued word is taken and every result is back, or the guard runs out
  task automatic wait_quiet();
    int unsigned guard;
    while (pending_events.size() != 0 || in_valid_i) @(posedge clk_i);
    guard = 0;
    while (expected_results.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // event word builders, every unused field random
  // ---------------------------------------------------------------------------
  function automatic in_word_t rand_word(logic [2:0] k);
    in_word_t w;
    w      = 8'($urandom);
    w.kind = k;
    return w;
  endfunction

  task automatic queue_present(int unsigned n);
    in_word_t w;
    repeat (n) begin
      w = rand_word(KIND_OBSERVE);
      w.drive_seen = 1'b1;
      if (w.media_known) w.media_loaded = 1'b1;
      pending_events.push_back(w);
    end
  endtask

  task automatic queue_absent(int unsigned n);
    in_word_t w;
    repeat (n) begin
      w = rand_word(KIND_OBSERVE);
      if ($urandom_range(0, 1)) begin
        w.drive_seen = 1'b0;
      end else begin
        w.media_known  = 1'b1;
        w.media_loaded = 1'b0;
      end
      pending_events.push_back(w);
    end
  endtask

  // run lengths stay short so huge targets do not eat the whole budget
  function automatic int unsigned run_cap(logic [CntW-1:0] goal);
    return ((goal > 10) ? 10 : goal) + 2;
  endfunction

  // mostly sensible sequences: presence runs toward a start, absence runs toward
  // a rearm, failures and commands between them, plus some noise
  task automatic queue_random(int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned len;
    in_word_t    w;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, run_cap(stable_goal));
        queue_present(len);
        made += len;
      end else if (pick < 50) begin
        len = $urandom_range(1, run_cap(rearm_goal));
        queue_absent(len);
        made += len;
      end else if (pick < 96) begin
        if (pick < 66) begin
          w = rand_word(KIND_FAILURE);
          if ($urandom_range(0, 3) != 0) w.failure_transient = 1'b1;
        end else if (pick < 73) begin
          w = rand_word(KIND_RETRY);
        end else if (pick < 79) begin
          w = rand_word(KIND_OBS_FAILED);
        end else if (pick < 83) begin
          w = rand_word(KIND_BLOCK);
        end else if (pick < 89) begin
          w = rand_word(KIND_EJECT);
        end else begin
          w = rand_word(3'($urandom_range(0, 5)));
        end
        pending_events.push_back(w);
        made++;
      end else begin
        // spare kinds, not counted as real events
        pending_events.push_back(rand_word($urandom_range(0, 1) ? KindSpare0 : KindSpare1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_word_t w;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset targets of three: start, one-shot hold, rearm paths
    idle_style = IDLE_UNIFORM;
    queue_present(4);
    w = rand_word(KIND_OBSERVE);
    w.drive_seen = 1'b0;
    pending_events.push_back(w);
    w = rand_word(KIND_OBSERVE);
    w.drive_seen   = 1'b1;
    w.media_known  = 1'b1;
    w.media_loaded = 1'b0;
    pending_events.push_back(w);
    pending_events.push_back(w);
    // unknown media status with the present bit low still counts as present
    w = rand_word(KIND_OBSERVE);
    w.drive_seen   = 1'b1;
    w.media_known  = 1'b0;
    w.media_loaded = 1'b0;
    pending_events.push_back(w);
    pending_events.push_back(rand_word(KIND_OBS_FAILED));
    // transient failures until the retry budget runs out
    repeat (4) begin
      w = rand_word(KIND_FAILURE);
      w.failure_transient = 1'b1;
      pending_events.push_back(w);
    end
    // retry loads the stable count, so one present observe starts at once
    pending_events.push_back(rand_word(KIND_RETRY));
    queue_present(1);
    w = rand_word(KIND_FAILURE);
    w.failure_transient = 1'b0;
    pending_events.push_back(w);
    pending_events.push_back(rand_word(KIND_BLOCK));
    w = rand_word(KIND_EJECT);
    w.tray_ejected = 1'b0;
    pending_events.push_back(w);
    w.tray_ejected = 1'b1;
    pending_events.push_back(w);
    pending_events.push_back(in_word_t'({KindSpare0, 5'b00000}));
    pending_events.push_back(in_word_t'({KindSpare1, 5'b11111}));
    pending_events.push_back(in_word_t'(8'h00));
    queue_present(3);
    queue_random(100);
    wait_quiet();

    // smallest nonzero targets, no retries allowed, junk register slot
    idle_style = IDLE_RARE;
    set_targets(8'd1, 8'd1, 8'd0);
    write_reg(RegUnused, 8'($urandom));
    queue_random(150);
    wait_quiet();

    // zero targets: counts never climb and every target is met
    idle_style = IDLE_NONE;
    set_targets(8'd0, 8'd0, 8'd0);
    queue_random(100);
    wait_quiet();

    // largest targets: only long runs reach them
    idle_style = IDLE_UNIFORM;
    set_targets(8'd255, 8'd255, 8'd255);
    queue_absent(256);
    queue_present(256);
    pending_events.push_back(rand_word(KIND_RETRY));
    queue_random(50);
    wait_quiet();

    // targets lowered beneath counts that are already higher
    idle_style = IDLE_RARE;
    set_targets(8'd5, 8'd4, 8'd2);
    queue_random(100);
    queue_absent(4);
    wait_quiet();
    write_reg(REG_REARM_TARGET, 8'd2);
    queue_absent(1);
    pending_events.push_back(rand_word(KIND_RETRY));
    wait_quiet();
    write_reg(REG_STABLE_TARGET, 8'd1);
    queue_present(2);
    queue_random(50);
    wait_quiet();

    // a couple of random small settings
    idle_style = IDLE_UNIFORM;
    repeat (2) begin
      set_targets(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  8'($urandom_range(0, 4)));
      queue_random(75);
      wait_quiet();
    end

    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("media_presence_arm_qualifier_top_tb: PASS");
    end else begin
      $display("media_presence_arm_qualifier_top_tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("media_presence_arm_qualifier_top_tb: FAIL");
    $finish;
  end

endmodule
